@@ hw/rtl/slsq_pkg.sv @@
// Shared constants, status codes and types of the slope sorted line queue.
`default_nettype none

package slsq_pkg;

  // Number of line entries the queue holds, one per cell.
  localparam int unsigned Depth = 64;
  // Width of every numerator and denominator.
  localparam int unsigned ValW = 32;
  // Width of the entry count, wide enough to hold Depth itself.
  localparam int unsigned CntW = $clog2(Depth + 1);

  // Result status codes.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_EMPTY    = 2'd2;
  localparam logic [1:0] STAT_ZERO_DEN = 2'd3;

  // Operation codes of the mode field.
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  // One stored line.
  typedef struct packed {
    logic            vert;
    logic [ValW-1:0] s_num;
    logic [ValW-1:0] s_den;
    logic [ValW-1:0] i_num;
    logic [ValW-1:0] i_den;
  } line_t;

  // Per-cycle commands broadcast to every cell.
  typedef struct packed {
    logic mul_en;
    logic cmp_en;
    logic ins_en;
    logic rem_en;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/slsq_cell.sv @@
// One cell of the sorted line chain: an entry, its valid bit and its slope compare.
`default_nettype none

module slsq_cell (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  slsq_pkg::cell_ctrl_t ctrl_i,
  input  slsq_pkg::line_t     new_line_i,
  input  slsq_pkg::line_t     prev_line_i,
  input  wire                 prev_valid_i,
  input  wire                 prev_hit_i,
  input  slsq_pkg::line_t     next_line_i,
  input  wire                 next_valid_i,
  output slsq_pkg::line_t     line_o,
  output logic                valid_o,
  output logic                hit_o
);

  localparam int unsigned PW = 2 * slsq_pkg::ValW;

  slsq_pkg::line_t line_q;
  logic            valid_q;
  logic            gb_q;
  logic signed [PW-1:0] p_ad_q, p_cb_q;
  logic            same_sign_q;
  logic            le;

  // The new line goes ahead of this entry when the entry is vertical, or both
  // are non-vertical and new slope <= stored slope. The cross products are
  // taken on raw fractions; opposite denominator signs flip the compare.
  assign le = same_sign_q ? (p_ad_q <= p_cb_q) : (p_ad_q >= p_cb_q);

  // An empty cell also marks the insert point.
  assign hit_o   = !valid_q || gb_q;
  assign line_o  = line_q;
  assign valid_o = valid_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      p_ad_q      <= PW'($signed(new_line_i.s_num)) * PW'($signed(line_q.s_den));
      p_cb_q      <= PW'($signed(line_q.s_num)) * PW'($signed(new_line_i.s_den));
      same_sign_q <= new_line_i.s_den[slsq_pkg::ValW-1] == line_q.s_den[slsq_pkg::ValW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gb_q <= 1'b0;
    end else if (ctrl_i.cmp_en) begin
      gb_q <= line_q.vert || (!new_line_i.vert && le);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.ins_en) begin
      if (prev_hit_i) begin
        valid_q <= prev_valid_i;
      end else if (hit_o) begin
        valid_q <= 1'b1;
      end
    end else if (ctrl_i.rem_en) begin
      valid_q <= next_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins_en) begin
      if (prev_hit_i) begin
        line_q <= prev_line_i;
      end else if (hit_o) begin
        line_q <= new_line_i;
      end
    end else if (ctrl_i.rem_en) begin
      line_q <= next_line_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/slope_sorted_line_queue_core.sv @@
// Top level of the slope sorted line queue: command port, sequencer and cell chain.
`default_nettype none

// Usage
// The block keeps up to 64 straight lines sorted by ascending slope, with
// vertical lines after all others. A command beat is taken at a rising edge
// where start is high and busy is low. Mode 0 inserts the line on the input
// ports ahead of the first stored line that is vertical or has a slope greater
// than or equal to its own; mode 1 removes the head line and returns it.
// Every command gives exactly one result beat, shown for one cycle while
// done_o is high. The receiver cannot stall, so the result must be captured in
// that cycle.
// An accepted insert passes through a capture step and then the cross-multiply,
// the compare and the shift of the chain; done_o rises in the cycle after the
// shift. A remove or a refused command skips the multiply and compare. busy is
// low again in the done_o cycle, so a new command can be taken there. The
// multiply and compare registers in every cell make an insert take longer than
// a remove.
// Slopes are compared exactly by signed cross-multiplication in each cell.
// Reset clears the entry count and all valid bits; stored line fields are not
// cleared and are never shown before they are written.

module slope_sorted_line_queue_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start,
  output logic        busy,
  input  wire         mode_i,
  input  wire         is_vertical_i,
  input  wire  [31:0] slope_num_i,
  input  wire  [31:0] slope_den_i,
  input  wire  [31:0] icept_num_i,
  input  wire  [31:0] icept_den_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic        out_vertical_o,
  output logic [31:0] out_slope_num_o,
  output logic [31:0] out_slope_den_o,
  output logic [31:0] out_icept_num_o,
  output logic [31:0] out_icept_den_o,
  output logic [6:0]  entry_count_o
);

  localparam int unsigned Depth = slsq_pkg::Depth;
  localparam int unsigned CntW  = slsq_pkg::CntW;

  // Sequencer state codes.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MUL   = 2'd1;
  localparam logic [1:0] S_CMP   = 2'd2;
  localparam logic [1:0] S_APPLY = 2'd3;

  logic [1:0]      state_q, state_d;
  logic            mode_q;
  logic [1:0]      stat_q, stat_d;
  slsq_pkg::line_t new_q, in_line;
  logic [CntW-1:0] occ_q, occ_d;
  logic            accept;

  slsq_pkg::cell_ctrl_t ctrl;

  slsq_pkg::line_t cell_line [Depth];
  logic [Depth-1:0] cell_valid;
  logic [Depth-1:0] cell_hit;

  logic            done_q;
  slsq_pkg::line_t res_line_q;
  logic [1:0]      res_stat_q;

  assign accept = start && !busy;
  assign busy   = state_q != S_IDLE;

  assign in_line = '{vert:  is_vertical_i,
                     s_num: slope_num_i,
                     s_den: slope_den_i,
                     i_num: icept_num_i,
                     i_den: icept_den_i};

  // Refusals are decided when the beat is taken, from the count at that time.
  always_comb begin
    stat_d = slsq_pkg::STAT_OK;
    if (mode_i == slsq_pkg::MODE_INSERT) begin
      if (!is_vertical_i && slope_den_i == '0) begin
        stat_d = slsq_pkg::STAT_ZERO_DEN;
      end else if (occ_q == CntW'(Depth)) begin
        stat_d = slsq_pkg::STAT_FULL;
      end
    end else if (occ_q == '0) begin
      stat_d = slsq_pkg::STAT_EMPTY;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (mode_i == slsq_pkg::MODE_INSERT && stat_d == slsq_pkg::STAT_OK) begin
            state_d = S_MUL;
          end else begin
            state_d = S_APPLY;
          end
        end
      end
      S_MUL:   state_d = S_CMP;
      S_CMP:   state_d = S_APPLY;
      S_APPLY: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl.mul_en = state_q == S_MUL;
    ctrl.cmp_en = state_q == S_CMP;
    ctrl.ins_en = state_q == S_APPLY && mode_q == slsq_pkg::MODE_INSERT
                  && stat_q == slsq_pkg::STAT_OK;
    ctrl.rem_en = state_q == S_APPLY && mode_q == slsq_pkg::MODE_REMOVE
                  && stat_q == slsq_pkg::STAT_OK;
  end

  always_comb begin
    occ_d = occ_q;
    if (ctrl.ins_en) begin
      occ_d = occ_q + CntW'(1);
    end else if (ctrl.rem_en) begin
      occ_d = occ_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      occ_q   <= '0;
      done_q  <= 1'b0;
      mode_q  <= slsq_pkg::MODE_INSERT;
      stat_q  <= slsq_pkg::STAT_OK;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      done_q  <= state_q == S_APPLY;
      if (accept) begin
        mode_q <= mode_i;
        stat_q <= stat_d;
      end
    end
  end

  // Command payload and result beat registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      new_q <= in_line;
    end
    if (state_q == S_APPLY) begin
      res_stat_q <= stat_q;
      res_line_q <= ctrl.rem_en ? cell_line[0] : '0;
    end
  end

  // The chain: each cell sees its neighbors' entries and insert marks.
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    slsq_pkg::line_t prev_line, next_line;
    logic            prev_valid, prev_hit, next_valid;

    if (i == 0) begin : g_head
      assign prev_line  = new_q;
      assign prev_valid = 1'b0;
      assign prev_hit   = 1'b0;
    end else begin : g_mid
      assign prev_line  = cell_line[i-1];
      assign prev_valid = cell_valid[i-1];
      assign prev_hit   = cell_hit[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      assign next_line  = '0;
      assign next_valid = 1'b0;
    end else begin : g_body
      assign next_line  = cell_line[i+1];
      assign next_valid = cell_valid[i+1];
    end

    slsq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_line_i   (new_q),
      .prev_line_i  (prev_line),
      .prev_valid_i (prev_valid),
      .prev_hit_i   (prev_hit),
      .next_line_i  (next_line),
      .next_valid_i (next_valid),
      .line_o       (cell_line[i]),
      .valid_o      (cell_valid[i]),
      .hit_o        (cell_hit[i])
    );
  end

  assign done_o          = done_q;
  assign status_o        = res_stat_q;
  assign out_vertical_o  = res_line_q.vert;
  assign out_slope_num_o = res_line_q.s_num;
  assign out_slope_den_o = res_line_q.s_den;
  assign out_icept_num_o = res_line_q.i_num;
  assign out_icept_den_o = res_line_q.i_den;
  assign entry_count_o   = 7'(occ_q);

endmodule

`default_nettype wire

@@ hw/rtl/slsq_checker.sv @@
// Port-level checks of the slope sorted line queue, bound to the top level.
`default_nettype none

module slsq_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        start,
  input wire        busy,
  input wire        done_o,
  input wire [1:0]  status_o,
  input wire [6:0]  entry_count_o
);

  // A taken command keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("command taken but block not busy");

  // A result beat is never followed directly by another.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two result beats in a row");

  // The block is free in the cycle that shows a result.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("busy while showing a result");

  // An empty report leaves nothing stored.
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == slsq_pkg::STAT_EMPTY |-> entry_count_o == 7'd0)
    else $error("empty status with nonzero count");

  // The count never exceeds the queue depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> entry_count_o <= 7'(slsq_pkg::Depth))
    else $error("entry count beyond depth");

endmodule

bind slope_sorted_line_queue_core slsq_checker u_slsq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .status_o      (status_o),
  .entry_count_o (entry_count_o)
);

`default_nettype wire

@@ test/slsq_line_checker.sv @@
// Checker for the slope sorted line queue: predicts each result beat and compares it.
`timescale 1ns / 100ps

module slsq_line_checker (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start,
  input  wire         busy,
  input  wire         mode_i,
  input  wire         is_vertical_i,
  input  wire  [31:0] slope_num_i,
  input  wire  [31:0] slope_den_i,
  input  wire  [31:0] icept_num_i,
  input  wire  [31:0] icept_den_i,
  input  wire         done_o,
  input  wire  [1:0]  status_o,
  input  wire         out_vertical_o,
  input  wire  [31:0] out_slope_num_o,
  input  wire  [31:0] out_slope_den_o,
  input  wire  [31:0] out_icept_num_o,
  input  wire  [31:0] out_icept_den_o,
  input  wire  [6:0]  entry_count_o,
  output int          errors,
  output int          pending,
  output int          results_seen,
  output int          full_hits,
  output int          empty_hits
);

  localparam int unsigned IdxW = $clog2(slsq_pkg::Depth);

  typedef struct packed {
    logic [1:0]                status;
    slsq_pkg::line_t           line;
    logic [slsq_pkg::CntW-1:0] count;
  } line_result_t;

  slsq_pkg::line_t stored_lines [slsq_pkg::Depth];
  int unsigned     stored_count = 0;
  line_result_t    expected_results [$];

  initial begin
    errors       = 0;
    pending      = 0;
    results_seen = 0;
    full_hits    = 0;
    empty_hits   = 0;
  end

  // Exact a/b <= c/d after moving each sign onto the numerator.
  function automatic logic slope_not_above(input logic [31:0] an, ad, bn, bd);
    longint a_n, a_d, b_n, b_d;
    a_n = longint'($signed(an));
    a_d = longint'($signed(ad));
    b_n = longint'($signed(bn));
    b_d = longint'($signed(bd));
    if (a_d < 0) begin
      a_n = -a_n;
      a_d = -a_d;
    end
    if (b_d < 0) begin
      b_n = -b_n;
      b_d = -b_d;
    end
    return (a_n * b_d) <= (b_n * a_d);
  endfunction

  // Applies one command to the tracked queue and returns the result it gives.
  function automatic line_result_t apply_command(input logic m, input slsq_pkg::line_t nl);
    line_result_t r;
    int unsigned  pos;
    logic         found;
    r = '0;
    r.status = slsq_pkg::STAT_OK;
    if (m == slsq_pkg::MODE_INSERT) begin
      if (!nl.vert && nl.s_den == '0) begin
        r.status = slsq_pkg::STAT_ZERO_DEN;
      end else if (stored_count >= slsq_pkg::Depth) begin
        r.status = slsq_pkg::STAT_FULL;
      end else begin
        pos   = stored_count;
        found = 1'b0;
        for (int i = 0; i < stored_count; i++) begin
          if (!found && (stored_lines[IdxW'(i)].vert ||
              (!nl.vert && slope_not_above(nl.s_num, nl.s_den,
                                           stored_lines[IdxW'(i)].s_num,
                                           stored_lines[IdxW'(i)].s_den)))) begin
            pos   = i;
            found = 1'b1;
          end
        end
        for (int i = stored_count; i > pos; i--) begin
          stored_lines[IdxW'(i)] = stored_lines[IdxW'(i-1)];
        end
        stored_lines[IdxW'(pos)] = nl;
        stored_count++;
      end
    end else if (stored_count == 0) begin
      r.status = slsq_pkg::STAT_EMPTY;
    end else begin
      r.line = stored_lines[0];
      for (int i = 1; i < stored_count; i++) begin
        stored_lines[IdxW'(i-1)] = stored_lines[IdxW'(i)];
      end
      stored_count--;
    end
    r.count = stored_count[slsq_pkg::CntW-1:0];
    return r;
  endfunction

  function automatic string describe(input line_result_t r);
    return $sformatf("status=%0d vert=%0b slope=%h/%h icept=%h/%h count=%0d",
                     r.status, r.line.vert, r.line.s_num, r.line.s_den,
                     r.line.i_num, r.line.i_den, r.count);
  endfunction

  always @(posedge clk_i) begin
    line_result_t    seen, want;
    slsq_pkg::line_t cmd_line;
    if (rst_ni) begin
      // The result beat of this edge belongs to an older command, so compare first.
      if (done_o === 1'b1) begin
        seen = {status_o, out_vertical_o, out_slope_num_o, out_slope_den_o,
                out_icept_num_o, out_icept_den_o, entry_count_o};
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("ERROR: result beat with none expected: %s", describe(seen));
        end else begin
          want = expected_results.pop_front();
          if (want.status == slsq_pkg::STAT_FULL) full_hits++;
          if (want.status == slsq_pkg::STAT_EMPTY) empty_hits++;
          if (seen !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("ERROR: result beat %0d mismatch", results_seen);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(seen));
            end
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        cmd_line = {is_vertical_i, slope_num_i, slope_den_i, icept_num_i, icept_den_i};
        expected_results.push_back(apply_command(mode_i, cmd_line));
      end
      pending = expected_results.size();
    end
  end

endmodule

@@ test/tb.sv @@
// Testbench top of the slope sorted line queue: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps

module tb;

  // Run length and safety net; the cycle limit sits far above the slowest correct run.
  localparam int RandomItems = 650;
  localparam int CycleLimit  = 100000;
  localparam int DrainCycles = 12;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        start         = 1'b0;
  logic        mode_i        = slsq_pkg::MODE_INSERT;
  logic        is_vertical_i = 1'b0;
  logic [31:0] slope_num_i   = '0;
  logic [31:0] slope_den_i   = 32'd1;
  logic [31:0] icept_num_i   = '0;
  logic [31:0] icept_den_i   = 32'd1;

  wire         busy;
  wire         done_o;
  wire  [1:0]  status_o;
  wire         out_vertical_o;
  wire  [31:0] out_slope_num_o;
  wire  [31:0] out_slope_den_o;
  wire  [31:0] out_icept_num_o;
  wire  [31:0] out_icept_den_o;
  wire  [6:0]  entry_count_o;

  int errors;
  int pending;
  int results_seen;
  int full_hits;
  int empty_hits;

  int cycle_count = 0;
  int beats_sent  = 0;
  int idle_pct    = 0;

  // Sender idling per quarter of the random part: none, heavy, none, moderate.
  int idle_table [4] = '{0, 72, 0, 38};

  always #6 clk_i = ~clk_i;

  slope_sorted_line_queue_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .is_vertical_i  (is_vertical_i),
    .slope_num_i    (slope_num_i),
    .slope_den_i    (slope_den_i),
    .icept_num_i    (icept_num_i),
    .icept_den_i    (icept_den_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .out_vertical_o (out_vertical_o),
    .out_slope_num_o(out_slope_num_o),
    .out_slope_den_o(out_slope_den_o),
    .out_icept_num_o(out_icept_num_o),
    .out_icept_den_o(out_icept_den_o),
    .entry_count_o  (entry_count_o)
  );

  slsq_line_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .is_vertical_i  (is_vertical_i),
    .slope_num_i    (slope_num_i),
    .slope_den_i    (slope_den_i),
    .icept_num_i    (icept_num_i),
    .icept_den_i    (icept_den_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .out_vertical_o (out_vertical_o),
    .out_slope_num_o(out_slope_num_o),
    .out_slope_den_o(out_slope_den_o),
    .out_icept_num_o(out_icept_num_o),
    .out_icept_den_o(out_icept_den_o),
    .entry_count_o  (entry_count_o),
    .errors         (errors),
    .pending        (pending),
    .results_seen   (results_seen),
    .full_hits      (full_hits),
    .empty_hits     (empty_hits)
  );

  // Watchdog: a hung handshake or a lost result beat ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d result beats outstanding",
               cycle_count, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Draws a 32-bit field value. Small values make equal slopes in different
  // forms (such as 1/2, 2/4 and -1/-2) common, the corner values stress the
  // exact cross-multiply, and full random words toggle every bit.
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = int'($urandom_range(8)) - 4;
      4: begin
        case ($urandom_range(3))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'hffff_ffff;
          default: v = 32'h0000_0001;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Drives one command beat and returns after the edge where it is taken and any
  // idle gap that follows. Called at a rising edge; start stays high into the
  // next beat unless the sender idles, in which case start drops and the fields
  // carry noise meanwhile. Each cycle of a gap is drawn on its own, so idle_pct
  // is the share of idle cycles among those where the block could take a beat.
  task automatic send_beat(input logic m, input logic v,
                           input logic [31:0] sn, input logic [31:0] sd,
                           input logic [31:0] inum, input logic [31:0] iden);
    mode_i        <= m;
    is_vertical_i <= v;
    slope_num_i   <= sn;
    slope_den_i   <= sd;
    icept_num_i   <= inum;
    icept_den_i   <= iden;
    start         <= 1'b1;
    // busy only moves after a rising edge, so the falling edge is a safe
    // place to see whether the coming edge takes the beat.
    do @(negedge clk_i); while (busy !== 1'b0);
    @(posedge clk_i);
    beats_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start         <= 1'b0;
      mode_i        <= 1'($urandom);
      is_vertical_i <= 1'($urandom);
      slope_num_i   <= $urandom;
      slope_den_i   <= $urandom;
      icept_num_i   <= $urandom;
      icept_den_i   <= $urandom;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  initial begin
    int random_sent;
    int seg_len;
    int insert_pct;
    int directed_sent;
    logic m;

    random_sent = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty remove, zero slope denominator on an empty and on a
    // filled queue, a vertical line with a zero denominator, equal slopes in
    // several forms, the signed extremes, then a full drain and one more
    // remove on the empty queue.
    idle_pct = 0;
    send_beat(slsq_pkg::MODE_REMOVE, 1'b0, 32'h5, 32'h7, 32'h1, 32'h1);
    send_beat(slsq_pkg::MODE_INSERT, 1'b0, 32'h3, 32'h0, 32'h1, 32'h1);
    send_beat(slsq_pkg::MODE_INSERT, 1'b1, 32'h5, 32'h0, 32'h7fff_ffff, 32'h8000_0000);
    send_beat(slsq_pkg::MODE_INSERT, 1'b0, 32'h1, 32'h2, 32'h0, 32'hffff_ffff);
    send_beat(slsq_pkg::MODE_INSERT, 1'b0, 32'h2, 32'h4, 32'h8000_0000, 32'h7fff_ffff);
    send_beat(slsq_pkg::MODE_INSERT, 1'b0, 32'hffff_ffff, 32'hffff_fffe, 32'h11, 32'h22);
    send_beat(slsq_pkg::MODE_INSERT, 1'b0, 32'h7fff_ffff, 32'h1, 32'hffff_ffff, 32'h0);
    send_beat(slsq_pkg::MODE_INSERT, 1'b0, 32'h8000_0000, 32'h1, 32'h3, 32'h4);
    send_beat(slsq_pkg::MODE_INSERT, 1'b0, 32'h8000_0000, 32'h8000_0000, 32'h5, 32'h6);
    send_beat(slsq_pkg::MODE_INSERT, 1'b0, 32'h1, 32'h8000_0000, 32'h7, 32'h8);
    send_beat(slsq_pkg::MODE_INSERT, 1'b0, 32'h0, 32'hffff_fffb, 32'h9, 32'ha);
    send_beat(slsq_pkg::MODE_INSERT, 1'b0, 32'hffff_ffff, 32'h7fff_ffff, 32'hb, 32'hc);
    send_beat(slsq_pkg::MODE_INSERT, 1'b1, $urandom, $urandom, $urandom, $urandom);
    send_beat(slsq_pkg::MODE_INSERT, 1'b0, 32'h7fff_ffff, 32'h0, 32'hd, 32'he);
    idle_pct = 38;
    repeat (12) send_beat(slsq_pkg::MODE_REMOVE, 1'b0, $urandom, $urandom, $urandom, $urandom);
    directed_sent = beats_sent;

    // Random part in segments: fills that run the queue into full, drains that
    // run it dry, and mixed traffic in between. The first segment is a fill.
    seg_len    = 100;
    insert_pct = 95;
    while (random_sent < RandomItems) begin
      for (int j = 0; j < seg_len && random_sent < RandomItems; j++) begin
        idle_pct = idle_table[2'((random_sent * 4) / RandomItems)];
        m = ($urandom_range(99) < insert_pct) ? slsq_pkg::MODE_INSERT : slsq_pkg::MODE_REMOVE;
        send_beat(m, $urandom_range(99) < 15, pick_value(), pick_value(),
                  pick_value(), pick_value());
        random_sent++;
      end
      case ($urandom_range(2))
        0: begin
          seg_len    = $urandom_range(80, 110);
          insert_pct = 95;
        end
        1: begin
          seg_len    = $urandom_range(30, 80);
          insert_pct = 10;
        end
        default: begin
          seg_len    = $urandom_range(20, 60);
          insert_pct = 55;
        end
      endcase
    end
    start <= 1'b0;

    // Let every outstanding result beat arrive, then watch a little longer for
    // stray beats.
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d command beats (%0d directed, %0d random) under varied sender gaps.",
             beats_sent, directed_sent, random_sent);
    $display("Checked %0d result beats: %0d full refusals, %0d empty removes, %0d mismatches.",
             results_seen, full_hits, empty_hits, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/slsq_pkg.sv
hw/rtl/slsq_cell.sv
hw/rtl/slope_sorted_line_queue_core.sv
hw/rtl/slsq_checker.sv
test/slsq_line_checker.sv
test/tb.sv
